/* src/fha_pkg.sv */
// Package for the free hole allocator: status, function and register codes.
// Used by free_hole_allocator_fit_policies; depends on nothing.
package fha_pkg;
  localparam int unsigned MaxHolesDefault = 64;

  localparam logic [2:0] StAlloc   = 3'd0;
  localparam logic [2:0] StCompact = 3'd1;
  localparam logic [2:0] StOom     = 3'd2;
  localparam logic [2:0] StDone    = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;

  localparam logic [1:0] FnInit  = 2'd0;
  localparam logic [1:0] FnAlloc = 2'd1;
  localparam logic [1:0] FnFree  = 2'd2;
  localparam logic [1:0] FnNone  = 2'd3;

  localparam logic [1:0] RegFitPolicy = 2'd0;
  localparam logic [1:0] RegMemSize   = 2'd1;
  localparam logic [1:0] RegResSize   = 2'd2;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

  localparam logic [16:0] AddrTop = 17'h10000;
endpackage

/* src/free_hole_allocator_fit_policies.sv */
// Free hole allocator with first, best and worst fit over a sorted hole table.
// Depends on fha_pkg; the hole table is one synchronous memory in this module.
//
//  channel | signals                                   | direction
//  in      | in_valid_i in_ready_o func req_size base | word in
//  out     | out_valid_o out_ready_i status base total | word out
//  cfg     | cfg_we_i cfg_idx_i cfg_data_i             | write only
//
// An item costs a scan of the hole table, a shift of the entries that must move, and a
// second scan that sums the hole sizes. The hole memory takes one read and one write a cycle.
// The table is empty after reset; no clearing pass is needed.
// A word is accepted only while the output register is empty or being read out.
module free_hole_allocator_fit_policies #(
  parameter int unsigned MAX_HOLES = fha_pkg::MaxHolesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [16:0] req_size_i,
  input  logic [15:0] free_base_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] alloc_base_o,
  output logic [16:0] free_total_o
);
  import fha_pkg::*;

  localparam int unsigned IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int unsigned CW = $clog2(MAX_HOLES + 1);
  localparam int unsigned SW = 18 + CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_SUM   = 3'd6;
  localparam logic [2:0] S_SUMW  = 3'd7;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] size;
  } hole_t;

  hole_t mem [MAX_HOLES];
  hole_t rd_q;

  logic        mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  hole_t       mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  logic [1:0]  fit_q;
  logic [16:0] msize_q, rsize_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= FitFirst;
      msize_q <= 17'd4096;
      rsize_q <= 17'd128;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFitPolicy: fit_q <= cfg_data_i[1:0];
        RegMemSize:   msize_q <= cfg_data_i;
        RegResSize:   rsize_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [2:0]  st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d;
  logic        rv_q, rv_d;
  logic [CW-1:0] ri_q, ri_d;
  logic [1:0]  fn_q, fn_d;
  logic [16:0] req_q, req_d;
  logic [15:0] fb_q, fb_d;
  logic        found_q, found_d, done_q, done_d;
  logic [CW-1:0] pick_q, pick_d;
  hole_t       ph_q, ph_d;
  hole_t       prev_q, prev_d;
  hole_t       succ_q, succ_d;
  logic        hs_q, hs_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [CW-1:0] pos_q, pos_d;
  logic        up_q, up_d;
  logic [2:0]  res_st_q, res_st_d;
  logic [15:0] res_b_q, res_b_d;
  logic        ov_q, ov_d;
  logic [2:0]  ost_q, ost_d;
  logic [15:0] ob_q, ob_d;
  logic [16:0] ot_q, ot_d;

  assign in_ready_o   = (st_q == S_IDLE) && (!ov_q || out_ready_i);
  assign out_valid_o  = ov_q;
  assign status_o     = ost_q;
  assign alloc_base_o = ob_q;
  assign free_total_o = ot_q;

  logic [16:0] top, res, fsize, clip;
  logic [16:0] pend;
  logic        fits, pm, sm;
  always_comb begin
    top  = (msize_q > AddrTop) ? AddrTop : msize_q;
    res  = (rsize_q > AddrTop) ? AddrTop : rsize_q;
    clip = AddrTop - {1'b0, fb_q};
    fsize = (req_q > clip) ? clip : req_q;
    pend = {1'b0, prev_q.base} + prev_q.size;
    pm   = (pos_q != '0) && (pend == {1'b0, fb_q});
    sm   = hs_q && (({1'b0, fb_q} + fsize) == {1'b0, succ_q.base});
    fits = rd_q.size >= req_q;
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; rv_d = 1'b0; ri_d = ri_q;
    fn_d = fn_q; req_d = req_q; fb_d = fb_q; found_d = found_q; done_d = done_q;
    pick_d = pick_q; ph_d = ph_q; prev_d = prev_q; succ_d = succ_q; hs_d = hs_q;
    sum_d = sum_q; pos_d = pos_q; up_d = up_q;
    res_st_d = res_st_q; res_b_d = res_b_q;
    ov_d = ov_q; ost_d = ost_q; ob_d = ob_q; ot_d = ot_q;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          fn_d = func_i; req_d = req_size_i; fb_d = free_base_i;
          found_d = 1'b0; done_d = 1'b0; sum_d = '0; i_d = '0; pos_d = '0;
          hs_d = 1'b0; res_st_d = StDone; res_b_d = '0;
          case (func_i)
            FnInit: begin
              if (top > res) begin
                mem_we = 1'b1; mem_wa = '0;
                mem_wd.base = res[15:0]; mem_wd.size = top - res;
                cnt_d = CW'(1);
              end else begin
                cnt_d = '0;
              end
              st_d = S_SUM;
            end
            FnAlloc, FnFree: st_d = S_SCAN;
            default: st_d = S_SUM;
          endcase
        end
      end
      S_SCAN: begin
        if (rv_q) begin
          sum_d = sum_q + SW'(rd_q.size);
          if (fn_q == FnAlloc) begin
            if (fits && !done_q) begin
              if (!found_q) begin
                found_d = 1'b1; pick_d = ri_q; ph_d = rd_q;
                if (fit_q != FitBest && fit_q != FitWorst) done_d = 1'b1;
              end else if (fit_q == FitBest && rd_q.size < ph_q.size) begin
                pick_d = ri_q; ph_d = rd_q;
              end else if (fit_q == FitWorst && rd_q.size > ph_q.size) begin
                pick_d = ri_q; ph_d = rd_q;
              end
            end
          end else if (!done_q) begin
            if (rd_q.base < fb_q) begin
              prev_d = rd_q; pos_d = ri_q + CW'(1);
            end else begin
              succ_d = rd_q; hs_d = 1'b1; done_d = 1'b1;
            end
          end
        end
        if (i_q < cnt_q) begin
          mem_ra = i_q[IW-1:0]; rv_d = 1'b1; ri_d = i_q; i_d = i_q + CW'(1);
        end else if (!rv_q) begin
          st_d = S_DEC;
        end
      end
      S_DEC: begin
        st_d = S_FIN;
        if (fn_q == FnAlloc) begin
          if (!found_q) begin
            res_st_d = (sum_q >= SW'(req_q)) ? StCompact : StOom;
          end else begin
            res_st_d = StAlloc; res_b_d = ph_q.base;
            if (ph_q.size == req_q) begin
              up_d = 1'b1; i_d = pick_q;
              cnt_d = cnt_q - CW'(1);
              st_d = (pick_q + CW'(1) < cnt_q) ? S_RD : S_FIN;
            end else begin
              mem_we = 1'b1; mem_wa = pick_q[IW-1:0];
              mem_wd.size = ph_q.size - req_q;
              mem_wd.base = ph_q.base + req_q[15:0];
            end
          end
        end else if (fsize != '0) begin
          if (pm && sm) begin
            mem_we = 1'b1; mem_wa = IW'(pos_q - CW'(1));
            mem_wd.base = prev_q.base; mem_wd.size = prev_q.size + fsize + succ_q.size;
            up_d = 1'b1; i_d = pos_q; cnt_d = cnt_q - CW'(1);
            st_d = (pos_q + CW'(1) < cnt_q) ? S_RD : S_FIN;
          end else if (pm) begin
            mem_we = 1'b1; mem_wa = IW'(pos_q - CW'(1));
            mem_wd.base = prev_q.base; mem_wd.size = prev_q.size + fsize;
          end else if (sm) begin
            mem_we = 1'b1; mem_wa = pos_q[IW-1:0];
            mem_wd.base = fb_q; mem_wd.size = succ_q.size + fsize;
          end else if (cnt_q >= CW'(MAX_HOLES)) begin
            res_st_d = StFull;
          end else begin
            up_d = 1'b0; i_d = cnt_q; cnt_d = cnt_q + CW'(1);
            if (cnt_q == pos_q) begin
              mem_we = 1'b1; mem_wa = pos_q[IW-1:0];
              mem_wd.base = fb_q; mem_wd.size = fsize;
            end else begin
              st_d = S_RD;
            end
          end
        end
      end
      S_RD: begin
        mem_ra = up_q ? IW'(i_q + CW'(1)) : IW'(i_q - CW'(1));
        st_d = S_WR;
      end
      S_WR: begin
        mem_we = 1'b1; mem_wa = i_q[IW-1:0]; mem_wd = rd_q;
        if (up_q) begin
          i_d = i_q + CW'(1);
          st_d = (i_q + CW'(2) < cnt_q + CW'(1)) ? S_RD : S_FIN;
        end else begin
          i_d = i_q - CW'(1);
          if (i_q - CW'(1) == pos_q) begin
            st_d = S_SUMW;
          end else begin
            st_d = S_RD;
          end
        end
      end
      S_SUMW: begin
        mem_we = 1'b1; mem_wa = pos_q[IW-1:0];
        mem_wd.base = fb_q; mem_wd.size = fsize;
        st_d = S_FIN;
      end
      S_FIN: begin
        sum_d = '0; i_d = '0; done_d = 1'b1; found_d = 1'b1;
        st_d = S_SCAN;
        fn_d = FnNone;
      end
      S_SUM: begin
        sum_d = '0; i_d = '0; done_d = 1'b1; st_d = S_SCAN; fn_d = FnNone;
      end
      default: st_d = S_IDLE;
    endcase

    if (fn_q == FnNone && st_q == S_SCAN && i_q >= cnt_q && !rv_q) begin
      st_d = S_IDLE;
      ov_d = 1'b1; ost_d = res_st_q; ob_d = res_b_q;
      ot_d = (sum_q > SW'(AddrTop)) ? AddrTop : sum_q[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; ov_q <= 1'b0; rv_q <= 1'b0; i_q <= '0;
      fn_q <= FnInit; done_q <= 1'b0; found_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d; rv_q <= rv_d; i_q <= i_d;
      fn_q <= fn_d; done_q <= done_d; found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q <= ri_d; req_q <= req_d; fb_q <= fb_d; pick_q <= pick_d; ph_q <= ph_d;
    prev_q <= prev_d; succ_q <= succ_d; hs_q <= hs_d; sum_q <= sum_d; pos_q <= pos_d;
    up_q <= up_d; res_st_q <= res_st_d; res_b_q <= res_b_d;
    ost_q <= ost_d; ob_q <= ob_d; ot_q <= ot_d;
  end
endmodule
